[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file psc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset (active-low reset).
`define PSC_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PSC_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/psc_pkg.sv]
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types and constants for the page sharing communication matrix.
// ----------------------------------------------------------------------------
package psc_pkg;

    localparam int ID_W        = 6;
    localparam int SLOT_IN_W   = 12;
    localparam int COUNT_W     = 32;
    localparam int BUMPS_W     = 2;
    localparam int REQ_W       = 2;
    localparam int SHR_W       = 14;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 40;

    localparam logic [REQ_W-1:0] REQ_ACCESS = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Sharer slot, most recent sharer in s0.
    typedef struct packed {
        logic            v1;
        logic            v0;
        logic [ID_W-1:0] s1;
        logic [ID_W-1:0] s0;
    } t_sharer;

    typedef struct packed {
        t_sharer         next;
        logic            want_a;
        logic [ID_W-1:0] peer_a;
        logic            want_b;
        logic [ID_W-1:0] peer_b;
    } t_plan;

    typedef struct packed {
        logic [1:0]           pad;
        logic [ID_W-1:0]      col_thread;
        logic [ID_W-1:0]      row_thread;
        logic [SLOT_IN_W-1:0] page_slot;
        logic [ID_W-1:0]      thread_id;
    } t_in_word;

    typedef struct packed {
        logic [5:0]         pad;
        logic [BUMPS_W-1:0] bumps_done;
        logic [COUNT_W-1:0] pair_count;
    } t_out_word;

    // Sharer update for one access; peers returned are candidates for a bump.
    function automatic t_plan plan_access(t_sharer e, logic [ID_W-1:0] tid);
        t_plan p;
        p        = '0;
        p.next   = e;
        if (!e.v0) begin
            p.next.s0 = tid;
            p.next.v0 = 1'b1;
        end else if (!e.v1) begin
            if (e.s0 != tid) begin
                p.want_a  = 1'b1;
                p.peer_a  = e.s0;
                p.next.s1 = e.s0;
                p.next.v1 = 1'b1;
                p.next.s0 = tid;
            end
        end else if (e.s0 != tid && e.s1 != tid) begin
            p.want_a  = 1'b1;
            p.peer_a  = e.s0;
            p.want_b  = 1'b1;
            p.peer_b  = e.s1;
            p.next.s1 = e.s0;
            p.next.s0 = tid;
        end else if (e.s0 == tid) begin
            p.want_a = 1'b1;
            p.peer_a = e.s1;
        end else begin
            // tid is the older sharer: swap
            p.want_a  = 1'b1;
            p.peer_a  = e.s0;
            p.next.s1 = e.s0;
            p.next.s0 = tid;
        end
        return p;
    endfunction

endpackage

[rtl/psc_shr_ram.sv]
// ----------------------------------------------------------------------------
// psc_shr_ram
// Sharer table: one read port, one write port, registered read data.
// ----------------------------------------------------------------------------
module psc_shr_ram import psc_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_sharer       o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_sharer       i_wr_data
);

    logic [SHR_W-1:0] r_mem [DEPTH];
    logic [SHR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = t_sharer'(r_rd_data);

endmodule

[rtl/psc_cnt_ram.sv]
// ----------------------------------------------------------------------------
// psc_cnt_ram
// Pair counter store: two read ports, one write port, registered read data.
// ----------------------------------------------------------------------------
module psc_cnt_ram import psc_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic               i_clk,
    input  logic               i_rd_en_a,
    input  logic [AW-1:0]      i_rd_addr_a,
    output logic [COUNT_W-1:0] o_rd_data_a,
    input  logic               i_rd_en_b,
    input  logic [AW-1:0]      i_rd_addr_b,
    output logic [COUNT_W-1:0] o_rd_data_b,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [COUNT_W-1:0] i_wr_data
);

    logic [COUNT_W-1:0] r_mem [DEPTH];
    logic [COUNT_W-1:0] r_rd_a;
    logic [COUNT_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en_a) begin
            r_rd_a <= r_mem[i_rd_addr_a];
        end
        if (i_rd_en_b) begin
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

[rtl/page_sharing_comm_matrix.sv]
// ----------------------------------------------------------------------------
// page_sharing_comm_matrix
// Per-page sharer tracking with a lower-triangular thread pair counter matrix.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// s_       in   i_s_tvalid/o_s_tready  tuser: req_type; tdata: tid,slot,row,col
// m_       out  o_m_tvalid/i_m_tready  tdata: pair_count, bumps_done
//
// One word at a time. Access steps: accept/sharer read, sharer write +
// counter reads, counter writes (two when two counters are bumped), result.
// Read: accept/counter read, capture, result. Clear: counter sweep over all
// THREAD_COUNT^2 cells, then result. Other request kinds: accept, result.
// The count RAM has one write port, so a double bump writes its counters in turn.
// After reset a clearing pass over max(PAGE_SLOTS, THREAD_COUNT^2) entries
// (4096 by default) empties both RAMs; o_s_tready stays low during it.
// A result waiting in the output register does not block the next accept.
// ----------------------------------------------------------------------------
module page_sharing_comm_matrix import psc_pkg::*; #(
    parameter int THREAD_COUNT = 64,
    parameter int PAGE_SLOTS   = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // [5:0] thread_id, [17:6] page_slot, [23:18] row_thread,
    // [29:24] col_thread, [31:30] zero
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]       i_s_tuser,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [31:0] pair_count, [33:32] bumps_done, [39:34] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int CELLS   = THREAD_COUNT * THREAD_COUNT;
    localparam int CELL_W  = $clog2(CELLS);
    localparam int SLOT_W  = $clog2(PAGE_SLOTS);
    localparam int SWEEP_D = (PAGE_SLOTS > CELLS) ? PAGE_SLOTS : CELLS;
    localparam int CLR_W   = $clog2(SWEEP_D);
    // PAGE_SLOTS must be at least 16, unchecked here; then the slot fold needs no larger shift
    localparam int FOLD_MAX_SHIFT = SLOT_IN_W - 4;
    localparam int SLOT_IN_MAX    = (1 << SLOT_IN_W) - 1;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SHR  = 3'd2;
    localparam logic [2:0] S_CNT  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    // page_slot modulo PAGE_SLOTS by restoring compare/subtract
    function automatic logic [SLOT_IN_W-1:0] fold_slot(logic [SLOT_IN_W-1:0] v_in);
        logic [SLOT_IN_W-1:0] v;
        v = v_in;
        for (int k = FOLD_MAX_SHIFT; k >= 0; k--) begin
            if ((PAGE_SLOTS << k) <= SLOT_IN_MAX) begin
                if (32'(v) >= (PAGE_SLOTS << k)) begin
                    v = v - SLOT_IN_W'(PAGE_SLOTS << k);
                end
            end
        end
        return v;
    endfunction

    function automatic logic pair_ok(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        return (32'(a) < THREAD_COUNT) && (32'(b) < THREAD_COUNT);
    endfunction

    // lower triangle: max * THREAD_COUNT + min
    function automatic logic [CELL_W-1:0] cell_of(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        logic [ID_W-1:0] hi;
        logic [ID_W-1:0] lo;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        return CELL_W'(hi) * CELL_W'(THREAD_COUNT) + CELL_W'(lo);
    endfunction

    t_in_word in_word;
    assign in_word = t_in_word'(i_s_tdata);

    // control
    logic [2:0]       r_state, n_state;
    logic [CLR_W-1:0] r_idx,   n_idx;
    logic             r_m_valid, n_m_valid;

    // per-item payload
    logic [ID_W-1:0]    r_tid,       n_tid;
    logic [SLOT_W-1:0]  r_slot,      n_slot;
    logic               r_rd_ok,     n_rd_ok;
    logic [CELL_W-1:0]  r_cell_a,    n_cell_a;
    logic [CELL_W-1:0]  r_cell_b,    n_cell_b;
    logic               r_bump_a,    n_bump_a;
    logic               r_bump_b,    n_bump_b;
    logic [COUNT_W-1:0] r_res_count, n_res_count;
    logic [BUMPS_W-1:0] r_res_bumps, n_res_bumps;
    t_out_word          r_m_data,    n_m_data;

    // RAM ports
    logic               shr_rd_en;
    logic [SLOT_W-1:0]  shr_rd_addr;
    t_sharer            shr_rd_data;
    logic               shr_wr_en;
    logic [SLOT_W-1:0]  shr_wr_addr;
    t_sharer            shr_wr_data;
    logic               cnt_rd_en_a, cnt_rd_en_b;
    logic [CELL_W-1:0]  cnt_rd_addr_a, cnt_rd_addr_b;
    logic [COUNT_W-1:0] cnt_rd_data_a, cnt_rd_data_b;
    logic               cnt_wr_en;
    logic [CELL_W-1:0]  cnt_wr_addr;
    logic [COUNT_W-1:0] cnt_wr_data;

    logic  s_accept;
    t_plan plan;
    logic  bump_a, bump_b;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign plan       = plan_access(shr_rd_data, r_tid);
    assign bump_a     = plan.want_a && pair_ok(r_tid, plan.peer_a);
    assign bump_b     = plan.want_b && pair_ok(r_tid, plan.peer_b);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_m_valid   = r_m_valid;
        n_tid       = r_tid;
        n_slot      = r_slot;
        n_rd_ok     = r_rd_ok;
        n_cell_a    = r_cell_a;
        n_cell_b    = r_cell_b;
        n_bump_a    = r_bump_a;
        n_bump_b    = r_bump_b;
        n_res_count = r_res_count;
        n_res_bumps = r_res_bumps;
        n_m_data    = r_m_data;

        shr_rd_en     = 1'b0;
        shr_rd_addr   = SLOT_W'(fold_slot(in_word.page_slot));
        shr_wr_en     = 1'b0;
        shr_wr_addr   = r_slot;
        shr_wr_data   = plan.next;
        cnt_rd_en_a   = 1'b0;
        cnt_rd_addr_a = cell_of(r_tid, plan.peer_a);
        cnt_rd_en_b   = 1'b0;
        cnt_rd_addr_b = cell_of(r_tid, plan.peer_b);
        cnt_wr_en     = 1'b0;
        cnt_wr_addr   = r_cell_a;
        cnt_wr_data   = cnt_rd_data_a + COUNT_W'(1);

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                // clearing pass over both RAMs
                shr_wr_en   = (32'(r_idx) < PAGE_SLOTS);
                shr_wr_addr = SLOT_W'(r_idx);
                shr_wr_data = '0;
                cnt_wr_en   = (32'(r_idx) < CELLS);
                cnt_wr_addr = CELL_W'(r_idx);
                cnt_wr_data = '0;
                if (32'(r_idx) == SWEEP_D - 1) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + CLR_W'(1);
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_tid       = in_word.thread_id;
                    n_slot      = shr_rd_addr;
                    n_rd_ok     = pair_ok(in_word.row_thread, in_word.col_thread);
                    n_res_count = '0;
                    n_res_bumps = '0;
                    unique case (i_s_tuser)
                        REQ_ACCESS: begin
                            shr_rd_en = 1'b1;
                            n_state   = S_SHR;
                        end
                        REQ_READ: begin
                            cnt_rd_en_a   = 1'b1;
                            cnt_rd_addr_a = cell_of(in_word.row_thread, in_word.col_thread);
                            n_state       = S_RD;
                        end
                        REQ_CLEAR: begin
                            n_idx   = '0;
                            n_state = S_CLR;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SHR: begin
                // sharer entry is out of the RAM: write back, fetch counters
                shr_wr_en   = 1'b1;
                cnt_rd_en_a = 1'b1;
                cnt_rd_en_b = 1'b1;
                n_cell_a    = cnt_rd_addr_a;
                n_cell_b    = cnt_rd_addr_b;
                n_bump_a    = bump_a;
                n_bump_b    = bump_b;
                n_res_bumps = BUMPS_W'(bump_a) + BUMPS_W'(bump_b);
                n_state     = S_CNT;
            end
            S_CNT: begin
                cnt_wr_en = r_bump_a;
                n_state   = r_bump_b ? S_WB : S_FIN;
            end
            S_WB: begin
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = r_cell_b;
                cnt_wr_data = cnt_rd_data_b + COUNT_W'(1);
                n_state     = S_FIN;
            end
            S_RD: begin
                n_res_count = r_rd_ok ? cnt_rd_data_a : '0;
                n_state     = S_FIN;
            end
            S_CLR: begin
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = CELL_W'(r_idx);
                cnt_wr_data = '0;
                if (32'(r_idx) == CELLS - 1) begin
                    n_idx   = '0;
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx + CLR_W'(1);
                end
            end
            S_FIN: begin
                // wait for the output register to free up
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid           = 1'b1;
                    n_m_data.pad        = '0;
                    n_m_data.bumps_done = r_res_bumps;
                    n_m_data.pair_count = r_res_count;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_idx     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tid       <= n_tid;
        r_slot      <= n_slot;
        r_rd_ok     <= n_rd_ok;
        r_cell_a    <= n_cell_a;
        r_cell_b    <= n_cell_b;
        r_bump_a    <= n_bump_a;
        r_bump_b    <= n_bump_b;
        r_res_count <= n_res_count;
        r_res_bumps <= n_res_bumps;
        r_m_data    <= n_m_data;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    psc_shr_ram #(
        .DEPTH (PAGE_SLOTS),
        .AW    (SLOT_W)
    ) u_shr_ram (
        .i_clk     (i_clk),
        .i_rd_en   (shr_rd_en),
        .i_rd_addr (shr_rd_addr),
        .o_rd_data (shr_rd_data),
        .i_wr_en   (shr_wr_en),
        .i_wr_addr (shr_wr_addr),
        .i_wr_data (shr_wr_data)
    );

    psc_cnt_ram #(
        .DEPTH (CELLS),
        .AW    (CELL_W)
    ) u_cnt_ram (
        .i_clk       (i_clk),
        .i_rd_en_a   (cnt_rd_en_a),
        .i_rd_addr_a (cnt_rd_addr_a),
        .o_rd_data_a (cnt_rd_data_a),
        .i_rd_en_b   (cnt_rd_en_b),
        .i_rd_addr_b (cnt_rd_addr_b),
        .o_rd_data_b (cnt_rd_data_b),
        .i_wr_en     (cnt_wr_en),
        .i_wr_addr   (cnt_wr_addr),
        .i_wr_data   (cnt_wr_data)
    );

endmodule

[rtl/psc_checker.sv]
// ----------------------------------------------------------------------------
// psc_checker
// Port-level checks for page_sharing_comm_matrix, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psc_checker import psc_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // stalled word holds
    `PSC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "output word changed while stalled")

    // at most two counters per access
    `PSC_ASSERT_ALL(a_bumps_range, i_clk, o_m_tvalid |-> o_m_tdata[33:32] != 2'd3, "bumps_done out of range")

    `PSC_ASSERT_ALL(a_pad_zero, i_clk, o_m_tvalid |-> o_m_tdata[39:34] == 6'd0, "output pad bits not zero")

    // one word in flight: ready drops after every accept
    `PSC_ASSERT_ALL(a_one_at_a_time, i_clk, i_s_tvalid && o_s_tready |=> !o_s_tready, "accepted back to back")

    // clearing pass follows reset
    `PSC_ASSERT_ALL(a_busy_after_reset, i_clk, !i_rst_n |=> !o_s_tready && !o_m_tvalid, "not busy after reset")

endmodule

bind page_sharing_comm_matrix psc_checker u_psc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

[sim/page_sharing_comm_matrix_test.sv]
// ----------------------------------------------------------------------------
// page_sharing_comm_matrix_test
// Self-checking bench for the page sharing communication matrix.
// Drives access, pair read, clear and unused request words through the
// input stream and mirrors sharer slots and pair counters in a scoreboard.
// Each output word is checked field by field against the oldest prediction.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module page_sharing_comm_matrix_test;
    import psc_pkg::*;

    localparam int THREADS      = 64;
    localparam int SLOTS        = 4096;
    localparam int RANDOM_WORDS = 1800;
    localparam int CLEAR_CAP    = 5;
    localparam int SETTLE       = 20;
    // Reset sweep plus a few clears (each a full counter sweep) plus stalled traffic,
    // taken several times over.
    localparam int CYCLE_LIMIT  = 1_000_000;

    // Request kind the block ignores; it still answers with a zero word.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the sharer slots and the pair counters, plus the
    // queue of output words still owed by the block.
    // ------------------------------------------------------------------------
    class pair_count_scoreboard;
        t_sharer            sharer_slots [SLOTS];
        logic [COUNT_W-1:0] pair_counts [THREADS*THREADS];
        t_out_word          owed_words [$];
        int                 bad_words;

        function new();
            foreach (sharer_slots[i]) sharer_slots[i] = '0;
            foreach (pair_counts[i]) pair_counts[i] = '0;
            bad_words = 0;
        endfunction

        // Lower-triangle cell of a pair, -1 when the pair has no counter.
        function int cell_of(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
            int hi;
            int lo;
            hi = (a > b) ? a : b;
            lo = (a > b) ? b : a;
            if (hi >= THREADS) return -1;
            return hi * THREADS + lo;
        endfunction

        function int bump_pair(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
            int c;
            c = cell_of(a, b);
            if (c < 0) return 0;
            pair_counts[c] = pair_counts[c] + 1'b1;     // wraps at 32 bits
            return 1;
        endfunction

        // Called on every accepted input word, in acceptance order.
        function void note_request(logic [REQ_W-1:0] kind, t_in_word w);
            t_out_word       r;
            t_sharer         e;
            logic [ID_W-1:0] tid;
            int              slot;
            int              n;
            int              c;
            r   = '0;
            n   = 0;
            tid = w.thread_id;
            case (kind)
                REQ_ACCESS: begin
                    slot = w.page_slot % SLOTS;
                    e    = sharer_slots[slot];
                    if (!e.v0) begin
                        e.s0 = tid;
                        e.v0 = 1'b1;
                    end else if (!e.v1) begin
                        if (e.s0 != tid) begin
                            n    = bump_pair(tid, e.s0);
                            e.s1 = e.s0;
                            e.v1 = 1'b1;
                            e.s0 = tid;
                        end
                    end else if (e.s0 != tid && e.s1 != tid) begin
                        n    = bump_pair(tid, e.s0);
                        n    = n + bump_pair(tid, e.s1);
                        e.s1 = e.s0;
                        e.s0 = tid;
                    end else if (e.s0 == tid) begin
                        n = bump_pair(tid, e.s1);
                    end else begin
                        // older sharer comes back: promote it
                        n    = bump_pair(tid, e.s0);
                        e.s1 = e.s0;
                        e.s0 = tid;
                    end
                    sharer_slots[slot] = e;
                    r.bumps_done       = n[BUMPS_W-1:0];
                end
                REQ_READ: begin
                    c = cell_of(w.row_thread, w.col_thread);
                    if (c >= 0) r.pair_count = pair_counts[c];
                end
                REQ_CLEAR: begin
                    foreach (pair_counts[i]) pair_counts[i] = '0;
                end
                default: ;
            endcase
            owed_words.push_back(r);
        endfunction

        // Called on every accepted output word.
        function void check_word(t_out_word got);
            t_out_word want;
            if (owed_words.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("result word with nothing pending: count=%0d bumps=%0d",
                             got.pair_count, got.bumps_done);
                return;
            end
            want = owed_words.pop_front();
            if (got.pair_count != want.pair_count || got.bumps_done != want.bumps_done) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("mismatch: count exp=%0d got=%0d, bumps exp=%0d got=%0d",
                             want.pair_count, got.pair_count,
                             want.bumps_done, got.bumps_done);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;      // thread_id, page_slot, row, col, zero
    logic [REQ_W-1:0]       i_s_tuser;      // req_type
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;      // pair_count, bumps_done, zero

    page_sharing_comm_matrix #(
        .THREAD_COUNT (THREADS),
        .PAGE_SLOTS   (SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    pair_count_scoreboard board;
    logic                 steady;           // no idling on either side when set
    int                   cycles;
    int                   clears_sent;
    logic [ID_W-1:0]      hot_threads [6];
    logic [SLOT_IN_W-1:0] hot_slots [12];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run guard: a hung handshake ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[page_sharing_comm_matrix] ERROR");
            $finish;
        end
    end

    // Receiver: ready drops in roughly a third of the cycles unless steady.
    always @(negedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 32);
    end

    // Output words are sampled at the rising edge, where the handshake counts.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_word(t_out_word'(o_m_tdata));
    end

    // ------------------------------------------------------------------------
    // Sender tasks. All entered and left at a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] tid,
                             input logic [SLOT_IN_W-1:0] slot,
                             input logic [ID_W-1:0] row, input logic [ID_W-1:0] col);
        t_in_word w;
        w            = '0;
        w.thread_id  = tid;
        w.page_slot  = slot;
        w.row_thread = row;
        w.col_thread = col;
        i_s_tvalid  <= 1'b1;
        i_s_tdata   <= w;
        i_s_tuser   <= kind;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_request(kind, w);
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input bit quiet);
        if (!quiet) begin
            while ($urandom_range(99) < 32) begin
                i_s_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
    endtask

    // Hold the input side until every owed word has come back.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (board.owed_words.size() != 0);
    endtask

    // Mostly a small set of threads so pairs repeat and sharer slots fill up.
    function automatic logic [ID_W-1:0] pick_thread();
        if ($urandom_range(99) < 75) return hot_threads[$urandom_range(5)];
        return ID_W'($urandom_range(THREADS - 1));
    endfunction

    function automatic logic [SLOT_IN_W-1:0] pick_slot();
        if ($urandom_range(99) < 85) return hot_slots[$urandom_range(11)];
        return SLOT_IN_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int          roll;
        logic [ID_W-1:0] ta;
        logic [ID_W-1:0] tb;
        bit          quiet;

        board       = new();
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = REQ_ACCESS;
        i_m_tready  = 1'b1;
        steady      = 1'b0;
        cycles      = 0;
        clears_sent = 0;
        foreach (hot_threads[i]) hot_threads[i] = ID_W'($urandom_range(THREADS - 1));
        foreach (hot_slots[i]) hot_slots[i] = SLOT_IN_W'($urandom);
        hot_slots[0] = '0;
        hot_slots[1] = '1;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every sharer transition on slot 0, extremes of each field,
        // diagonal reads, symmetric reads, the unused kind, and a clear that
        // must leave the sharer slots intact.
        send_word(REQ_READ,   '0, '0, '0, '0);         // empty diagonal
        send_word(REQ_ACCESS, '0, '0, '0, '0);         // no sharer yet
        send_word(REQ_ACCESS, '0, '0, '0, '0);         // same lone sharer
        send_word(REQ_ACCESS, '1, '0, '0, '0);         // second sharer joins
        send_word(REQ_ACCESS, '1, '0, '0, '0);         // newest sharer again
        send_word(REQ_ACCESS, '0, '0, '0, '0);         // older sharer, swap
        send_word(REQ_ACCESS, 6'h2A, '0, '0, '0);      // third thread, two bumps
        send_word(REQ_ACCESS, 6'h15, '1, '0, '0);      // top slot
        send_word(REQ_ACCESS, 6'h2A, 12'hAAA, '1, '1);
        send_word(REQ_ACCESS, 6'h15, 12'h555, '1, '1);
        send_word(REQ_ACCESS, 6'h2A, 12'h555, '0, '0);
        send_word(REQ_READ,   '1, '1, '1, '0);         // pair (63,0)
        send_word(REQ_READ,   '0, '0, '0, '1);         // same pair, mirrored
        send_word(REQ_READ,   '0, '0, 6'h2A, 6'h15);
        send_word(REQ_READ,   '0, '0, 6'h2A, 6'h2A);   // diagonal
        send_word(REQ_READ,   '0, '0, '1, '1);         // top diagonal
        send_word(REQ_UNUSED, '1, '1, '1, '1);         // ignored kind
        send_word(REQ_CLEAR,  '1, '1, '1, '1);
        send_word(REQ_READ,   '0, '0, '1, '0);         // cleared to zero
        send_word(REQ_ACCESS, 6'h2A, '0, '0, '0);      // slot 0 still remembered
        send_word(REQ_READ,   '0, '0, '0, 6'h2A);
        drain_results();

        // Random: mostly accesses on hot slots and threads, reads of hot pairs,
        // a few unused kinds and rare clears.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            quiet = (n >= 400 && n < 700);
            if (n == 400) steady <= 1'b1;
            if (n == 700) steady <= 1'b0;
            if (n == 1000) drain_results();
            idle_gap(quiet);
            roll = $urandom_range(999);
            ta   = pick_thread();
            tb   = pick_thread();
            if (roll < 3 && clears_sent < CLEAR_CAP) begin
                clears_sent++;
                send_word(REQ_CLEAR, ID_W'($urandom), SLOT_IN_W'($urandom),
                          ID_W'($urandom), ID_W'($urandom));
            end else if (roll < 30) begin
                send_word(REQ_UNUSED, ID_W'($urandom), SLOT_IN_W'($urandom),
                          ID_W'($urandom), ID_W'($urandom));
            end else if (roll < 300) begin
                send_word(REQ_READ, ID_W'($urandom), SLOT_IN_W'($urandom), ta, tb);
            end else begin
                send_word(REQ_ACCESS, ta, pick_slot(), ID_W'($urandom), ID_W'($urandom));
            end
        end

        // Wind down: everything owed must arrive, then a short quiet window
        // catches any stray word.
        drain_results();
        repeat (SETTLE) @(negedge i_clk);
        if (board.bad_words == 0 && board.owed_words.size() == 0) begin
            $display("[page_sharing_comm_matrix] OK");
        end else begin
            $display("[page_sharing_comm_matrix] ERROR");
        end
        $finish;
    end

endmodule

[page_sharing_comm_matrix.f]
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_shr_ram.sv
rtl/psc_cnt_ram.sv
rtl/page_sharing_comm_matrix.sv
rtl/psc_checker.sv
sim/page_sharing_comm_matrix_test.sv
